// ----- design/hsv_pkg.sv -----
// hsv_pkg: field widths shared by the RGB to HSV converter and its channel interfaces.
// No dependencies.
package hsv_pkg;

	localparam int RGB_W = 8;	// one colour channel
	localparam int HUE_W = 15;	// hue field
	localparam int SAT_W = 15;	// saturation field
	localparam int VAL_W = 8;	// value field

	typedef logic [RGB_W-1:0] chan_t;
	typedef logic [HUE_W-1:0] hue_t;
	typedef logic [SAT_W-1:0] sat_t;
	typedef logic [VAL_W-1:0] val_t;

endpackage

// ----- design/hsv_rgb_if.sv -----
// hsv_rgb_if: valid/ready channel carrying one RGB pixel request.
// Depends on hsv_pkg.
interface hsv_rgb_if;
	import hsv_pkg::*;

	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// ----- design/hsv_res_if.sv -----
// hsv_res_if: valid/ready channel carrying one HSV result request.
// Depends on hsv_pkg.
interface hsv_res_if;
	import hsv_pkg::*;

	logic valid;
	logic ready;
	hue_t hue;
	sat_t saturation;
	val_t value_level;

	modport source (output valid, output hue, output saturation, output value_level,
		input ready);
	modport sink   (input valid, input hue, input saturation, input value_level,
		output ready);

endinterface

// ----- design/hsv_div.sv -----
// hsv_div: pipelined restoring divider, one quotient bit per register stage.
// Standalone; the quotient must be known to fit in QUO_W bits.
module hsv_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 8,
	parameter int QUO_W = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic             rem_nz
);

	localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic [NUM_W-1:0] rem_s [0:QUO_W];
	logic [DEN_W-1:0] den_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		localparam int K = QUO_W - 1 - i;
		logic [CW-1:0] trial;
		logic [CW-1:0] rem_ext;
		logic          fits;

		assign trial   = CW'(den_s[i]) << K;
		assign rem_ext = CW'(rem_s[i]);
		assign fits    = rem_ext >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= den_s[i];
				rem_s[i+1] <= fits ? NUM_W'(rem_ext - trial) : rem_s[i];
				quo_s[i+1] <= {quo_s[i][QUO_W-2:0], fits};
			end
		end
	end

	assign quo    = quo_s[QUO_W];
	assign rem_nz = |rem_s[QUO_W];

endmodule

// ----- design/rgb_to_hsv_convert.sv -----
// rgb_to_hsv_convert: streaming 8-bit RGB to fixed-point HSV converter, top level.
// Depends on hsv_pkg, hsv_rgb_if, hsv_res_if and hsv_div.
//
// Usage
//   pixel  : sink channel, one RGB pixel per request (red, green, blue bytes).
//   result : source channel, one HSV request per pixel, in input order.
//            hue in 2^-HUE_FRAC_BITS degree units in [0, 360 deg),
//            saturation as percent with SAT_FRAC_BITS fraction bits,
//            value_level as the largest channel.
//   Pipeline: a pixel passes the stage 1 register, the divider stages and the output
//   register, in that order; QW is the wider of the two quotient widths.
//   Throughput: one pixel per clock unless stalled; both divisions run through hsv_div,
//   which settles one quotient bit per pipeline stage, so the stage count follows QW.
//   Reset (arst_n low) empties the pipeline: all valid bits clear. pixel.ready is
//   already high while reset is held, as the output register is empty; requests
//   are taken from the first rising edge after release.
//   Stall: when result.valid is high and result.ready low, the whole pipeline
//   holds and pixel.ready drops; nothing is lost or repeated. Requests already in
//   flight keep moving up to the output register while it is empty.
module rgb_to_hsv_convert #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int SAT_FRAC_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	hsv_rgb_if.sink   pixel,
	hsv_res_if.source result
);
	import hsv_pkg::*;

	localparam int HSCALE  = 1 << HUE_FRAC_BITS;
	localparam int HUE_MUL = 60 * HSCALE;
	localparam int SAT_MUL = 100 << SAT_FRAC_BITS;
	localparam int HUE_QW  = $clog2(HUE_MUL + 1);
	localparam int SAT_QW  = $clog2(SAT_MUL + 1);
	localparam int QW      = (HUE_QW > SAT_QW) ? HUE_QW : SAT_QW;
	localparam int HNUM_W  = $clog2(HUE_MUL * 255 + 1);
	localparam int SNUM_W  = $clog2(SAT_MUL * 255 + 1);
	// signed width holding -60 deg .. +360 deg in hue units
	localparam int HSW     = $clog2(360 * HSCALE + 1) + 1;

	// which channel is the maximum; ties go red, then green
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sect_t;

	// what travels alongside the dividers
	typedef struct packed {
		val_t  val;
		logic  zero;	// grey pixel: hue and saturation forced to 0
		logic  neg;	// hue difference is negative
		sect_t sect;
	} side_t;

	// global advance: the output register is free or being emptied
	logic en;

	// ---- stage 1: max/min, delta, hue difference, scaled numerators ----
	chan_t mx, mn, dlt, pos_c, neg_c, absd;
	sect_t sect;
	logic  dneg;

	always_comb begin
		mx = (pixel.red >= pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue > mx) mx = pixel.blue;
		mn = (pixel.red <= pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue < mn) mn = pixel.blue;
		dlt = mx - mn;

		// difference terms per sector: (g - b), (b - r), (r - g)
		if (pixel.red == mx) begin
			sect  = SECT_RED;
			pos_c = pixel.green;
			neg_c = pixel.blue;
		end else if (pixel.green == mx) begin
			sect  = SECT_GREEN;
			pos_c = pixel.blue;
			neg_c = pixel.red;
		end else begin
			sect  = SECT_BLUE;
			pos_c = pixel.red;
			neg_c = pixel.green;
		end
		dneg = pos_c < neg_c;
		absd = dneg ? (neg_c - pos_c) : (pos_c - neg_c);
	end

	logic              v_s1;
	logic [HNUM_W-1:0] hnum_s1;
	logic [SNUM_W-1:0] snum_s1;
	chan_t             delta_s1;
	chan_t             max_s1;
	side_t             side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hnum_s1  <= HNUM_W'(absd) * HNUM_W'(HUE_MUL);
			snum_s1  <= SNUM_W'(dlt) * SNUM_W'(SAT_MUL);
			delta_s1 <= dlt;
			max_s1   <= mx;
			side_s1  <= '{val: VAL_W'(mx), zero: (dlt == '0), neg: dneg, sect: sect};
		end
	end

	// ---- divider stages ----
	logic [QW-1:0] hue_quo, sat_quo;
	logic          hue_nz;

	hsv_div #(
		.NUM_W (HNUM_W),
		.DEN_W (RGB_W),
		.QUO_W (QW)
	) u_hue_div (
		.clk    (clk),
		.en     (en),
		.num    (hnum_s1),
		.den    (delta_s1),
		.quo    (hue_quo),
		.rem_nz (hue_nz)
	);

	hsv_div #(
		.NUM_W (SNUM_W),
		.DEN_W (RGB_W),
		.QUO_W (QW)
	) u_sat_div (
		.clk    (clk),
		.en     (en),
		.num    (snum_s1),
		.den    (max_s1),
		.quo    (sat_quo),
		.rem_nz ()
	);

	// sideband and valid line matching the divider depth
	logic  vld_line [0:QW-1];
	side_t sb_line  [0:QW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < QW; j++) vld_line[j] <= 1'b0;
		end else if (en) begin
			vld_line[0] <= v_s1;
			for (int j = 1; j < QW; j++) vld_line[j] <= vld_line[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_line[0] <= side_s1;
			for (int j = 1; j < QW; j++) sb_line[j] <= sb_line[j-1];
		end
	end

	// ---- final stage: sector offset, floor of negative part, wrap ----
	side_t                side_f;
	logic signed [HSW-1:0] base, frac, hsum, hwrap;

	assign side_f = sb_line[QW-1];

	always_comb begin
		unique case (side_f.sect)
			SECT_RED:   base = '0;
			SECT_GREEN: base = HSW'(120 * HSCALE);
			SECT_BLUE:  base = HSW'(240 * HSCALE);
			default:    base = '0;
		endcase
		// floor(-a/d) = -(q + (rem != 0))
		frac  = side_f.neg ? -(HSW'(hue_quo) + HSW'(hue_nz)) : HSW'(hue_quo);
		hsum  = base + frac;
		hwrap = hsum[HSW-1] ? hsum + HSW'(360 * HSCALE) : hsum;
	end

	logic res_valid_q;
	hue_t hue_q;
	sat_t sat_q;
	val_t val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= vld_line[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= side_f.zero ? '0 : HUE_W'(hwrap);
			sat_q <= side_f.zero ? '0 : SAT_W'(sat_quo);
			val_q <= side_f.val;
		end
	end

	assign en                 = !res_valid_q || result.ready;
	assign pixel.ready        = en;
	assign result.valid       = res_valid_q;
	assign result.hue         = hue_q;
	assign result.saturation  = sat_q;
	assign result.value_level = val_q;

	// ---- checks ----
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> v_s1)
		else $error("accepted pixel did not reach stage 1");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(vld_line[QW-1]))
		else $error("pipeline moved during a stall");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_line[QW-1] && side_f.zero) |=>
		(result.hue == '0 && result.saturation == '0))
		else $error("grey pixel gave non-zero hue or saturation");

	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_line[QW-1]) |=>
		(result.valid && result.value_level == $past(side_f.val)))
		else $error("result lost or value_level mismatched");

endmodule

// ----- bench/tb_rgb_to_hsv_convert.sv -----
// tb_rgb_to_hsv_convert: self-checking bench for the RGB to HSV converter, directed pixels, a
// random stream under random idling on both channels, then a back-to-back stretch without idling.
// Depends on hsv_pkg, hsv_rgb_if, hsv_res_if and the rgb_to_hsv_convert design.
module tb_rgb_to_hsv_convert;
	import hsv_pkg::*;

	localparam int HUE_FRAC_BITS = 6;
	localparam int SAT_FRAC_BITS = 8;
	// pipeline latency of the block with the default fraction widths
	localparam int PIPE_LATENCY = 17;
	localparam int MIXED_ITEMS = 1400;
	localparam int STEADY_ITEMS = 400;

	typedef struct packed {
		hue_t hue;
		sat_t saturation;
		val_t value_level;
	} hsv_t;

	logic clk = 1'b0;
	logic arst_n;

	hsv_rgb_if pixel_ch ();
	hsv_res_if result_ch ();

	rgb_to_hsv_convert #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.SAT_FRAC_BITS(SAT_FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_ch),
		.result(result_ch)
	);

	// HSV results still owed by the block, oldest first
	hsv_t expected_hsv[$];
	int err_count = 0;
	int sent_count = 0;
	int got_count = 0;
	// random idling on both channels; cleared for the last stretch of the run
	bit idle_on = 1'b1;

	always #4 clk = ~clk;

	// Exact integer HSV of one pixel at the bench's fraction widths.
	// Hue divides with floor toward minus infinity, then wraps into one turn.
	function automatic hsv_t hsv_from_rgb(input chan_t r, input chan_t g, input chan_t b);
		longint rl, gl, bl, top, bottom, delta, diff, offs, num, q, hscale, full;
		hsv_t res;
		rl = r;
		gl = g;
		bl = b;
		hscale = longint'(1) << HUE_FRAC_BITS;
		full = 360 * hscale;
		top = (rl > gl) ? rl : gl;
		if (bl > top) top = bl;
		bottom = (rl < gl) ? rl : gl;
		if (bl < bottom) bottom = bl;
		delta = top - bottom;
		res.hue = '0;
		res.saturation = '0;
		res.value_level = val_t'(top);
		if (delta > 0) begin
			res.saturation = sat_t'((delta * 100 * (longint'(1) << SAT_FRAC_BITS)) / top);
			// red wins a tie for the maximum, then green
			if (rl == top) begin
				diff = gl - bl;
				offs = 0;
			end else if (gl == top) begin
				diff = bl - rl;
				offs = 120;
			end else begin
				diff = rl - gl;
				offs = 240;
			end
			num = 60 * hscale * diff + offs * hscale * delta;
			q = num / delta;
			if ((num % delta) != 0 && num < 0) q -= 1;
			q = q % full;
			if (q < 0) q += full;
			// cast keeps the low 15 bits, as the field does for wide fractions
			res.hue = hue_t'(q);
		end
		return res;
	endfunction

	// One pixel request: optional idle burst, then hold valid until accepted.
	// ready is sampled just after the edge, so it is the value the block saw at that edge.
	task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.red <= r;
		pixel_ch.green <= g;
		pixel_ch.blue <= b;
		do @(posedge clk); while (!pixel_ch.ready);
		expected_hsv.push_back(hsv_from_rgb(r, g, b));
		sent_count++;
	endtask

	// Random pixel, weighted towards grey, tied maxima, saturated channels and wrapped hue.
	task automatic send_random_pixel();
		chan_t r, g, b, base;
		int kind;
		int rot;
		kind = $urandom_range(0, 19);
		r = chan_t'($urandom);
		g = chan_t'($urandom);
		b = chan_t'($urandom);
		base = chan_t'($urandom);
		rot = $urandom_range(0, 2);
		if (kind < 3) begin
			// grey or within a step or two of grey
			r = base;
			g = (kind == 0) ? base : base + chan_t'($urandom_range(0, 2));
			b = (kind == 0) ? base : base - chan_t'($urandom_range(0, 2));
		end else if (kind < 6) begin
			// two channels share the maximum
			base = chan_t'($urandom_range(1, 255));
			if (rot == 0) begin
				r = base; g = base; b = chan_t'($urandom_range(0, base));
			end else if (rot == 1) begin
				g = base; b = base; r = chan_t'($urandom_range(0, base));
			end else begin
				r = base; b = base; g = chan_t'($urandom_range(0, base));
			end
		end else if (kind < 8) begin
			// channels at or next to the ends of the range
			r = ($urandom_range(0, 1) != 0) ? 8'hFF - chan_t'($urandom_range(0, 1))
				: chan_t'($urandom_range(0, 1));
			g = ($urandom_range(0, 1) != 0) ? 8'hFF - chan_t'($urandom_range(0, 1))
				: chan_t'($urandom_range(0, 1));
			b = ($urandom_range(0, 1) != 0) ? 8'hFF - chan_t'($urandom_range(0, 1))
				: chan_t'($urandom_range(0, 1));
		end else if (kind < 10) begin
			// red on top with green under blue: raw hue negative
			r = chan_t'($urandom_range(2, 255));
			b = chan_t'($urandom_range(1, r));
			g = chan_t'($urandom_range(0, b - 1));
		end
		send_pixel(r, g, b);
	endtask

	// Result side: random back-pressure bursts while idling is on, otherwise always ready.
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 15);
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// Each accepted result against the oldest owed request, field by field.
	always @(posedge clk) begin
		hsv_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got_count++;
			if (expected_hsv.size() == 0) begin
				$error("result with nothing owed: hue %0d saturation %0d value_level %0d",
					result_ch.hue, result_ch.saturation, result_ch.value_level);
				err_count++;
			end else begin
				want = expected_hsv.pop_front();
				if (result_ch.hue !== want.hue) begin
					$error("hue: expected %0d, actual %0d", want.hue, result_ch.hue);
					err_count++;
				end
				if (result_ch.saturation !== want.saturation) begin
					$error("saturation: expected %0d, actual %0d", want.saturation,
						result_ch.saturation);
					err_count++;
				end
				if (result_ch.value_level !== want.value_level) begin
					$error("value_level: expected %0d, actual %0d", want.value_level,
						result_ch.value_level);
					err_count++;
				end
			end
		end
	end

	// Black, white, mid grey, primaries, secondaries and single-step extremes.
	task automatic test_corner_pixels();
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h80, 8'h80, 8'h80);
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hFF);
		send_pixel(8'h00, 8'hFF, 8'hFF);
		send_pixel(8'h01, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFE, 8'hFE);
		send_pixel(8'h00, 8'h01, 8'hFF);
		send_pixel(8'hAA, 8'h55, 8'hAA);
	endtask

	// Shared maxima: red beats green, green beats blue, red beats blue.
	task automatic test_max_ties();
		send_pixel(8'hFF, 8'hFF, 8'h00);
		send_pixel(8'hC8, 8'hC8, 8'h32);
		send_pixel(8'h0A, 8'hC8, 8'hC8);
		send_pixel(8'hFF, 8'h00, 8'hFF);
		send_pixel(8'hC8, 8'h0A, 8'hC8);
	endtask

	// Red on top with green below blue: hue floored downward, then wrapped by a full turn.
	task automatic test_wrapped_hue();
		send_pixel(8'hFF, 8'h00, 8'h01);
		send_pixel(8'hC8, 8'h0A, 8'h64);
		send_pixel(8'hFF, 8'h00, 8'hFE);
		send_pixel(8'h07, 8'h00, 8'h03);
		send_pixel(8'hFF, 8'hFD, 8'hFE);
	endtask

	task automatic test_mixed_stream();
		for (int i = 0; i < MIXED_ITEMS; i++) send_random_pixel();
	endtask

	// Last part of the run: no idling on either side, one request per clock.
	task automatic test_back_to_back();
		idle_on = 1'b0;
		for (int i = 0; i < STEADY_ITEMS; i++) send_random_pixel();
	endtask

	initial begin
		int waited;
		arst_n <= 1'b0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.red <= '0;
		pixel_ch.green <= '0;
		pixel_ch.blue <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_pixels();
		test_max_ties();
		test_wrapped_hue();
		test_mixed_stream();
		test_back_to_back();
		pixel_ch.valid <= 1'b0;

		// drain, then keep clocking to catch stray results
		waited = 0;
		while (expected_hsv.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (expected_hsv.size() != 0) begin
			$error("%0d results never arrived", expected_hsv.size());
			err_count++;
		end

		$display("Converted %0d pixels (%0d results checked): corners, ties, wrapped hue,",
			sent_count, got_count);
		$display("then a random stream with idling on both sides and a back-to-back stretch.");
		if (err_count == 0) begin
			$display("rgb_to_hsv_convert verification clean");
		end else begin
			$display("rgb_to_hsv_convert verification failed");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4000000;
		$display("rgb_to_hsv_convert verification failed");
		$finish;
	end

endmodule
